/* rtl/core/b64e_pkg.sv */
// b64e_pkg: shared types, command codes and the default alphabet of the encoder
// depends on nothing; imported by the encoder top level and its checker
`timescale 1ns / 1ps

package b64e_pkg;

  // alphabet geometry: 64 symbols plus the pad entry
  localparam int unsigned TABLE_DEPTH = 65;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned MAX_OPS     = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [7:0]       char_t;

  localparam idx_t PAD_ENTRY = idx_t'(64);

  // input command codes
  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_LAST  = 2'd1,
    CMD_END   = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  // default character of an alphabet entry that was never rewritten
  function automatic char_t b64e_std_char(idx_t idx);
    char_t c;
    c = 8'h3d;
    if (idx < idx_t'(26)) begin
      c = 8'(8'h41 + {1'b0, idx});
    end else if (idx < idx_t'(52)) begin
      c = 8'(8'h61 + {1'b0, idx} - 8'd26);
    end else if (idx < idx_t'(62)) begin
      c = 8'(8'h30 + {1'b0, idx} - 8'd52);
    end else if (idx == idx_t'(62)) begin
      c = 8'h2b;
    end else if (idx == idx_t'(63)) begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage

/* rtl/core/b64e_ram.sv */
// b64e_ram: generic single-write, single-read ram with registered read data
// depends on nothing; used for the alphabet store of the encoder
`timescale 1ns / 1ps

module b64e_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/base64_encode_custom_alphabet.sv */
// base64_encode_custom_alphabet: streaming base64 encoder, loadable alphabet
// depends on b64e_pkg and b64e_ram
//
//   channel   dir  tdata                                  tuser        tlast
//   s_axis    in   [7:0] data_byte, [14:8] table_index    [1:0] cmd    -
//   m_axis    out  [7:0] out_char                         -            last_char
//
// an item is decoded into 0..4 operations as it is accepted; one operation per
// cycle goes to the alphabet ram, a read only with room in the output queue, so an
// item holds the job slot until all its operations have gone (a table write has
// one, an item without output none); sustained rate is one character per cycle
// while m_axis accepts, set by the single ram read port; ram reads are registered.
// reset clears per-entry valid bits, so the table reads the standard alphabet
// and '=' at once; no clearing pass is needed.
// a stalled m_axis fills a two-entry output queue, then reads stop; writes do not.
`timescale 1ns / 1ps

module base64_encode_custom_alphabet
  import b64e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [14:8] table_index, [15] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_char
  output logic        m_axis_tlast
);

  // input fields
  cmd_e  in_cmd;
  char_t in_byte;
  idx_t  in_index;
  logic  in_xfer;

  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_byte  = s_axis_tdata[7:0];
  assign in_index = s_axis_tdata[14:8];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // group state
  logic [1:0] phase_q, phase_d;
  logic [3:0] lo_q, lo_d;

  // job slot: queued operations of the current item
  idx_t       job_idx_q [MAX_OPS];
  idx_t       job_idx_d [MAX_OPS];
  logic [2:0] job_cnt_q, job_cnt_d;
  logic       job_wr_q, job_wr_d;
  logic       job_last_q, job_last_d;
  char_t      job_wdata_q, job_wdata_d;

  // decode results
  idx_t       push_op [2];
  logic [2:0] push_n;
  logic [1:0] push_ph;
  logic [3:0] push_lo;
  logic [1:0] fl_ph;
  logic [3:0] fl_lo;
  idx_t       fl_op [3];
  logic [2:0] fl_n;

  // read pipeline and output queue
  logic       op_fire, op_rd, op_wr, room;
  logic       rd_pend_q, rd_last_q, rd_vld_q;
  idx_t       rd_idx_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  char_t      ram_rdata, push_char;
  char_t      fifo_char_q [2];
  logic       fifo_last_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fifo_cnt_q;
  logic       pop;

  // one byte into the group
  always_comb begin
    push_op[0] = '0;
    push_op[1] = '0;
    case (phase_q)
      2'd0: begin
        push_op[0] = idx_t'(in_byte[7:2]);
        push_n     = 3'd1;
        push_ph    = 2'd1;
        push_lo    = {2'b00, in_byte[1:0]};
      end
      2'd1: begin
        push_op[0] = idx_t'({lo_q[1:0], in_byte[7:4]});
        push_n     = 3'd1;
        push_ph    = 2'd2;
        push_lo    = in_byte[3:0];
      end
      default: begin
        push_op[0] = idx_t'({lo_q[3:0], in_byte[7:6]});
        push_op[1] = idx_t'(in_byte[5:0]);
        push_n     = 3'd2;
        push_ph    = 2'd0;
        push_lo    = 4'd0;
      end
    endcase
  end

  // flush of the open group with pad characters
  always_comb begin
    fl_ph    = (in_cmd == CMD_END) ? phase_q : push_ph;
    fl_lo    = (in_cmd == CMD_END) ? lo_q : push_lo;
    fl_op[0] = '0;
    fl_op[1] = PAD_ENTRY;
    fl_op[2] = PAD_ENTRY;
    case (fl_ph)
      2'd1: begin
        fl_op[0] = idx_t'({fl_lo[1:0], 4'b0000});
        fl_n     = 3'd3;
      end
      2'd2: begin
        fl_op[0] = idx_t'({fl_lo[3:0], 2'b00});
        fl_n     = 3'd2;
      end
      default: begin
        fl_n = 3'd0;
      end
    endcase
  end

  // sequencer: one ram access per cycle, read only with room downstream
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign room    = ({1'b0, fifo_cnt_q} + {2'b00, rd_pend_q}) < (pop ? 3'd3 : 3'd2);
  assign op_fire = (job_cnt_q != 3'd0) && (job_wr_q || room);
  assign op_rd   = op_fire && !job_wr_q;
  assign op_wr   = op_fire && job_wr_q;
  assign s_axis_tready = (job_cnt_q == 3'd0) || ((job_cnt_q == 3'd1) && op_fire);

  // next job and group state
  always_comb begin
    phase_d     = phase_q;
    lo_d        = lo_q;
    job_cnt_d   = job_cnt_q;
    job_wr_d    = job_wr_q;
    job_last_d  = job_last_q;
    job_wdata_d = job_wdata_q;
    for (int k = 0; k < MAX_OPS; k++) begin
      job_idx_d[k] = job_idx_q[k];
    end
    if (op_fire) begin
      for (int k = 0; k < MAX_OPS - 1; k++) begin
        job_idx_d[k] = job_idx_q[k+1];
      end
      job_cnt_d = job_cnt_q - 3'd1;
    end
    if (in_xfer) begin
      job_wr_d    = 1'b0;
      job_last_d  = 1'b0;
      job_wdata_d = in_byte;
      unique case (in_cmd)
        CMD_DATA: begin
          job_idx_d[0] = push_op[0];
          job_idx_d[1] = push_op[1];
          job_cnt_d    = push_n;
          phase_d      = push_ph;
          lo_d         = push_lo;
        end
        CMD_LAST: begin
          job_idx_d[0] = push_op[0];
          if (push_n == 3'd1) begin
            job_idx_d[1] = fl_op[0];
            job_idx_d[2] = fl_op[1];
            job_idx_d[3] = fl_op[2];
          end else begin
            job_idx_d[1] = push_op[1];
            job_idx_d[2] = fl_op[0];
            job_idx_d[3] = fl_op[1];
          end
          job_cnt_d  = push_n + fl_n;
          job_last_d = 1'b1;
          phase_d    = 2'd0;
          lo_d       = 4'd0;
        end
        CMD_END: begin
          job_idx_d[0] = fl_op[0];
          job_idx_d[1] = fl_op[1];
          job_idx_d[2] = fl_op[2];
          job_cnt_d    = fl_n;
          job_last_d   = 1'b1;
          phase_d      = 2'd0;
          lo_d         = 4'd0;
        end
        CMD_WRITE: begin
          job_idx_d[0] = in_index;
          job_wr_d     = 1'b1;
          job_cnt_d    = (in_index <= PAD_ENTRY) ? 3'd1 : 3'd0;
        end
        default: begin
          job_cnt_d = 3'd0;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 2'd0;
      lo_q      <= 4'd0;
      job_cnt_q <= 3'd0;
      job_wr_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      lo_q      <= lo_d;
      job_cnt_q <= job_cnt_d;
      job_wr_q  <= job_wr_d;
      rd_pend_q <= op_rd;
      if (op_wr) begin
        valid_q[job_idx_q[0]] <= 1'b1;
      end
    end
  end

  // job payload and read tags
  always_ff @(posedge clk_i) begin
    job_last_q  <= job_last_d;
    job_wdata_q <= job_wdata_d;
    for (int k = 0; k < MAX_OPS; k++) begin
      job_idx_q[k] <= job_idx_d[k];
    end
    if (op_rd) begin
      rd_idx_q  <= job_idx_q[0];
      rd_vld_q  <= valid_q[job_idx_q[0]];
      rd_last_q <= job_last_q && (job_cnt_q == 3'd1);
    end
  end

  // alphabet store
  b64e_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (op_wr),
    .waddr_i(job_idx_q[0]),
    .wdata_i(job_wdata_q),
    .re_i   (op_rd),
    .raddr_i(job_idx_q[0]),
    .rdata_o(ram_rdata)
  );

  // entries never written read as the standard alphabet
  assign push_char = rd_vld_q ? ram_rdata : b64e_std_char(rd_idx_q);

  // output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      fifo_cnt_q <= 2'd0;
    end else begin
      if (rd_pend_q) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fifo_cnt_q <= 2'(fifo_cnt_q + {1'b0, rd_pend_q} - {1'b0, pop});
    end
  end

  // output queue storage
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      fifo_char_q[wr_ptr_q] <= push_char;
      fifo_last_q[wr_ptr_q] <= rd_last_q;
    end
  end

  assign m_axis_tvalid = (fifo_cnt_q != 2'd0);
  assign m_axis_tdata  = fifo_char_q[rd_ptr_q];
  assign m_axis_tlast  = fifo_last_q[rd_ptr_q];

endmodule

/* rtl/core/b64e_checker.sv */
// b64e_assert: port-level assertions for the base64 encoder
// depends on b64e_pkg; bound to base64_encode_custom_alphabet
`timescale 1ns / 1ps

module b64e_assert
  import b64e_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled character holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // a table write never blocks the following transfer
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE) |=> s_axis_tready)
    else $error("input not ready after a table write");

  // out of reset the block is empty and ready
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty after reset");

  // checked once after reset: a character can only show up after some input transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |=> ##1 !m_axis_tvalid ||
      $past(s_axis_tvalid && s_axis_tready, 2) || $past(s_axis_tvalid && s_axis_tready, 3))
    else $error("output without input");

endmodule

bind base64_encode_custom_alphabet b64e_assert u_b64e_assert (.*);
